FILE: sv/aglsc_pkg.sv
// ----------------------------------------------------------------------------
// aglsc_pkg
// Shared types and constants for the gain / lowpass / soft-clip core.
// ----------------------------------------------------------------------------
package aglsc_pkg;

  localparam int SAMPLE_WIDTH_DEF = 24;
  localparam int COEFF_WIDTH_DEF  = 16;

  // multiplier operand B width; holds 27.0 + x^2 in Q28 as a positive value
  localparam int MB_W = 34;

  // shaper fixed point, 28 fractional bits
  localparam int SH_FRAC = 28;
  localparam logic [MB_W-1:0] SH_OFF  = MB_W'(161061274);   // 0.6
  localparam logic [MB_W-1:0] SH_POST = MB_W'(145722105);   // 19/35
  localparam logic [MB_W-1:0] SH_27   = MB_W'(27) << SH_FRAC;

  // divider sizes
  localparam int DIV_NW = 64;
  localparam int DIV_QW = 32;

  // register file
  localparam int ADDR_W = 4;
  localparam logic signed [15:0] GAIN_RST = 16'sd4096;
  localparam int POLE_RST = 13625;

  typedef enum logic [1:0] {
    REG_GAIN = 2'd0,
    REG_POLE = 2'd1,
    REG_SAT  = 2'd2,
    REG_NONE = 2'd3
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GAIN,
    ST_FSET,
    ST_FILT,
    ST_PREP,
    ST_SQ,
    ST_NUM,
    ST_DIV,
    ST_POST,
    ST_OUT
  } state_t;

endpackage

FILE: sv/aglsc_sample_if.sv
// ----------------------------------------------------------------------------
// aglsc_sample_if
// Input sample channel: valid/ready with one signed sample per transaction.
// ----------------------------------------------------------------------------
interface aglsc_sample_if #(
  parameter int W = 24
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

FILE: sv/aglsc_result_if.sv
// ----------------------------------------------------------------------------
// aglsc_result_if
// Result channel: valid/ready with the processed sample and its clip flag.
// ----------------------------------------------------------------------------
interface aglsc_result_if #(
  parameter int W = 24
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] sample_out;
  logic                clipped;

  modport source (output valid, output sample_out, output clipped, input ready);
  modport sink   (input valid, input sample_out, input clipped, output ready);
endinterface

FILE: sv/audio_gain_lowpass_softclip_core.sv
// ----------------------------------------------------------------------------
// audio_gain_lowpass_softclip_core
// Gain, one-pole lowpass and optional cubic-rational soft clip on audio.
// ----------------------------------------------------------------------------
// Usage:
//   sample_ch carries one signed Q1.23 sample per transaction (valid/ready).
//   result_ch returns one processed sample plus a clip flag per input.
//   Gain, pole and clip enable are set over APB at byte offsets 0, 4, 8.
//   Write them only while the core is idle; the block does not enforce it.
// Sample flow:
//   One sample at a time. All products go through a single bit-serial
//   multiplier, and the shaper quotient through a restoring divider. The
//   next sample is accepted once the result has been loaded into the
//   output register, with the clipper on or off.
// Reset:
//   rst clears the filter state to zero and loads gain 1.0, pole 13625 and
//   clipper off. No result is pending after reset.
// Stalls:
//   A finished result sits in the output register until taken; the next
//   sample is accepted and processed meanwhile, and waits in the final
//   state only if the previous result is still held.
// ----------------------------------------------------------------------------
module audio_gain_lowpass_softclip_core #(
  parameter int SAMPLE_WIDTH = aglsc_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEFF_WIDTH  = aglsc_pkg::COEFF_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [aglsc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  aglsc_sample_if.sink                 sample_ch,
  aglsc_result_if.source               result_ch
);
  import aglsc_pkg::*;

  localparam int SW  = SAMPLE_WIDTH;
  localparam int CWD = COEFF_WIDTH;
  localparam int MW  = (SW + 1 > 32) ? SW + 1 : 32;
  localparam int PW  = MW + MB_W;
  localparam int XW  = 40;
  // rescale into / out of the shaper's Q28 domain
  localparam int LSH = (SW <= 27) ? 27 - SW : 0;
  localparam int RSH = (SW > 27) ? SW - 27 : 0;
  localparam int UL  = (SW >= 27) ? SW - 27 : 0;
  localparam int UR  = (SW < 27) ? 27 - SW : 0;
  localparam int UBIAS = (1 << UR) >> 1;

  // configuration
  logic signed [15:0] gain;
  logic [CWD-1:0]     pole_coeff;
  logic               saturate_enable;

  aglsc_regs #(.COEFF_WIDTH(CWD)) u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .gain, .pole_coeff, .saturate_enable
  );

  // shared arithmetic units
  logic                 mul_go;
  logic                 mul_done;
  logic signed [MW-1:0] opa;
  logic signed [MB_W-1:0] opb;
  logic signed [PW-1:0] prod;

  aglsc_sermul #(.AW(MW), .BW(MB_W)) u_mul (
    .clk, .rst, .start(mul_go), .a(opa), .b(opb), .done(mul_done), .prod
  );

  logic               div_go;
  logic               div_done;
  logic [DIV_NW-1:0]  dividend;
  logic [MB_W-1:0]    den;
  logic [DIV_QW-1:0]  quo;

  aglsc_serdiv #(.NW(DIV_NW), .DW(MB_W), .QW(DIV_QW)) u_div (
    .clk, .rst, .start(div_go), .dividend, .divisor(den), .done(div_done), .quo
  );

  state_t state, state_next;

  logic signed [SW-1:0] fstate;
  logic signed [SW-1:0] p_reg;
  logic signed [SW-1:0] res;
  logic                 clip;
  logic signed [31:0]   xs;
  logic                 nsign;
  logic signed [32:0]   qs;

  logic                 accept;
  logic                 out_load;
  logic                 out_valid;
  logic signed [SW-1:0] out_sample;
  logic                 out_clip;

  // gain stage rounding and saturation
  logic signed [PW-1:0] g_sum;
  logic signed [PW-1:0] g_shr;
  logic                 g_ovf;
  logic signed [SW-1:0] g_sat;

  always_comb begin
    g_sum = prod + PW'(2048);
    g_shr = g_sum >>> 12;
    g_ovf = !((&g_shr[PW-1:SW-1]) || !(|g_shr[PW-1:SW-1]));
    if (g_ovf) begin
      g_sat = g_shr[PW-1] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
    end else begin
      g_sat = g_shr[SW-1:0];
    end
  end

  // filter: p*2^C + b*(s-p) + half, then drop C bits
  logic signed [SW:0]   f_diff;
  logic signed [PW-1:0] f_acc;
  logic signed [SW-1:0] f_y;

  always_comb begin
    f_diff = (SW+1)'(fstate) - (SW+1)'(p_reg);
    f_acc  = (PW'(p_reg) <<< CWD) + prod + PW'(1 << (CWD - 1));
    f_y    = f_acc[CWD +: SW];
  end

  // shaper input X = y/4 - 0.6 in Q28
  logic signed [XW-1:0] x_full;

  always_comb begin
    x_full = ((XW'(fstate) <<< LSH) >>> RSH) - XW'(signed'(SH_OFF));
  end

  // x^2, numerator and denominator terms
  logic [29:0]     x2;
  logic [MB_W-1:0] num_b;
  logic [MB_W-1:0] den_next;

  always_comb begin
    x2       = prod[SH_FRAC +: 30];
    num_b    = SH_27 + MB_W'(x2);
    den_next = SH_27 + (MB_W'(x2) << 3) + MB_W'(x2);
  end

  // magnitude of the numerator plus half the divisor
  logic signed [PW-1:0] n_mag;
  logic [DIV_NW-1:0]    div_in;

  always_comb begin
    n_mag  = prod[PW-1] ? -prod : prod;
    div_in = n_mag[DIV_NW-1:0] + DIV_NW'(den >> 1);
  end

  // output offset, scale back to the sample format, saturate
  logic signed [XW-1:0] o_sum;
  logic signed [XW-1:0] o_val;
  logic                 o_ovf;
  logic signed [SW-1:0] o_sat;

  always_comb begin
    o_sum = (XW'(qs) <<< 2) + XW'((SH_POST << 2) + MB_W'(UBIAS));
    o_val = (o_sum >>> UR) <<< UL;
    o_ovf = !((&o_val[XW-1:SW-1]) || !(|o_val[XW-1:SW-1]));
    if (o_ovf) begin
      o_sat = o_val[XW-1] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
    end else begin
      o_sat = o_val[SW-1:0];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (sample_ch.valid) state_next = ST_GAIN;
      ST_GAIN: if (mul_done) state_next = ST_FSET;
      ST_FSET: state_next = ST_FILT;
      ST_FILT: if (mul_done) state_next = saturate_enable ? ST_PREP : ST_OUT;
      ST_PREP: state_next = ST_SQ;
      ST_SQ:   if (mul_done) state_next = ST_NUM;
      ST_NUM:  if (mul_done) state_next = ST_DIV;
      ST_DIV:  if (div_done) state_next = ST_POST;
      ST_POST: state_next = ST_OUT;
      ST_OUT:  if (!out_valid || result_ch.ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    sample_ch.ready = (state == ST_IDLE);
    out_load        = (state == ST_OUT) && (!out_valid || result_ch.ready);
  end

  assign accept = sample_ch.valid && sample_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // unit launch pulses
  always_ff @(posedge clk) begin
    if (rst) begin
      mul_go <= 1'b0;
      div_go <= 1'b0;
    end else begin
      mul_go <= accept || (state == ST_FSET) || (state == ST_PREP) ||
                ((state == ST_SQ) && mul_done);
      div_go <= (state == ST_NUM) && mul_done;
    end
  end

  // filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      fstate <= '0;
    end else if ((state == ST_FILT) && mul_done) begin
      fstate <= f_y;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        opa  <= MW'(sample_ch.sample_in);
        opb  <= MB_W'(gain);
        clip <= 1'b0;
      end
      ST_GAIN: begin
        if (mul_done) begin
          p_reg <= g_sat;
          clip  <= g_ovf;
        end
      end
      ST_FSET: begin
        opa <= MW'(f_diff);
        opb <= MB_W'({1'b0, pole_coeff});
      end
      ST_FILT: begin
        if (mul_done) begin
          res <= f_y;
        end
      end
      ST_PREP: begin
        xs  <= x_full[31:0];
        opa <= MW'(signed'(x_full[31:0]));
        opb <= MB_W'(signed'(x_full[31:0]));
      end
      ST_SQ: begin
        if (mul_done) begin
          opa <= MW'(xs);
          opb <= signed'(num_b);
          den <= den_next;
        end
      end
      ST_NUM: begin
        if (mul_done) begin
          dividend <= div_in;
          nsign    <= prod[PW-1];
        end
      end
      ST_DIV: begin
        if (div_done) begin
          qs <= nsign ? -signed'({1'b0, quo}) : signed'({1'b0, quo});
        end
      end
      ST_POST: begin
        res  <= o_sat;
        clip <= clip | o_ovf;
      end
      ST_OUT: ;
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (result_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_sample <= res;
      out_clip   <= clip;
    end
  end

  assign result_ch.valid      = out_valid;
  assign result_ch.sample_out = out_sample;
  assign result_ch.clipped    = out_clip;

endmodule

FILE: sv/aglsc_regs.sv
// ----------------------------------------------------------------------------
// aglsc_regs
// APB register file: gain, pole coefficient and soft-clip enable.
// ----------------------------------------------------------------------------
module aglsc_regs #(
  parameter int COEFF_WIDTH = aglsc_pkg::COEFF_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [aglsc_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output logic signed [15:0]             gain,
  output logic [COEFF_WIDTH-1:0]         pole_coeff,
  output logic                           saturate_enable
);
  import aglsc_pkg::*;

  reg_idx_t               idx;
  logic                   wr;
  logic [COEFF_WIDTH-1:0] pole_next;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr     = psel && penable && pwrite;

  // only the low 16 bits of the written pole value survive
  always_comb begin
    for (int i = 0; i < COEFF_WIDTH; i++) begin
      pole_next[i] = (i < 16) ? pwdata[i] : 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gain            <= GAIN_RST;
      pole_coeff      <= COEFF_WIDTH'(POLE_RST);
      saturate_enable <= 1'b0;
    end else if (wr) begin
      unique case (idx)
        REG_GAIN: gain            <= signed'(pwdata[15:0]);
        REG_POLE: pole_coeff      <= pole_next;
        REG_SAT:  saturate_enable <= pwdata[0];
        REG_NONE: ;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (idx)
      REG_GAIN: prdata = 32'(gain);
      REG_POLE: prdata = 32'(pole_coeff);
      REG_SAT:  prdata = 32'(saturate_enable);
      REG_NONE: prdata = '0;
    endcase
  end

endmodule

FILE: sv/aglsc_sermul.sv
// ----------------------------------------------------------------------------
// aglsc_sermul
// Bit-serial signed multiplier: one bit of B per cycle, add-and-shift.
// ----------------------------------------------------------------------------
module aglsc_sermul #(
  parameter int AW = 32,
  parameter int BW = aglsc_pkg::MB_W
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [AW-1:0]    a,
  input  logic signed [BW-1:0]    b,
  output logic                    done,
  output logic signed [AW+BW-1:0] prod
);
  localparam int CW = $clog2(BW);

  logic signed [AW+BW-1:0] acc;
  logic signed [AW+BW-1:0] acc_next;
  logic signed [AW-1:0]    areg;
  logic signed [AW:0]      addend;
  logic signed [AW:0]      sum;
  logic [CW-1:0]           cnt;
  logic                    busy;
  logic                    last;

  assign last = (cnt == CW'(BW - 1));
  assign prod = acc;

  // the sign bit of B carries negative weight
  always_comb begin
    if (!acc[0]) begin
      addend = '0;
    end else if (last) begin
      addend = -(AW+1)'(areg);
    end else begin
      addend = (AW+1)'(areg);
    end
    sum      = (AW+1)'(signed'(acc[AW+BW-1:BW])) + addend;
    acc_next = {sum, acc[BW-1:1]};
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (last) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      areg <= a;
      acc  <= {{AW{1'b0}}, b};
    end else if (busy) begin
      acc <= acc_next;
    end
  end

endmodule

FILE: sv/aglsc_serdiv.sv
// ----------------------------------------------------------------------------
// aglsc_serdiv
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module aglsc_serdiv #(
  parameter int NW = aglsc_pkg::DIV_NW,
  parameter int DW = aglsc_pkg::MB_W,
  parameter int QW = aglsc_pkg::DIV_QW
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [QW-1:0] quo
);
  localparam int CW = $clog2(QW);

  logic [DW-1:0] rem;
  logic [DW-1:0] dreg;
  logic [QW-1:0] qsh;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;
  logic [CW-1:0] cnt;
  logic          busy;
  logic          last;

  assign last  = (cnt == CW'(QW - 1));
  assign trial = {rem, qsh[QW-1]};
  assign diff  = trial - {1'b0, dreg};
  assign ge    = (trial >= {1'b0, dreg});
  assign quo   = qsh;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (last) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

  // quotient fits QW bits, so the upper dividend part starts below the divisor
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= DW'(dividend[NW-1:QW]);
      qsh  <= dividend[QW-1:0];
      dreg <= divisor;
    end else if (busy) begin
      rem <= ge ? diff[DW-1:0] : trial[DW-1:0];
      qsh <= {qsh[QW-2:0], ge};
    end
  end

endmodule
